### hw/rtl/wrm_pkg.sv
// Shared types and constants for the windowed RSI and mean block.
package wrm_pkg;

  // Fixed widths of the payload ports.
  localparam int PRICE_PORT_W = 32;
  localparam int COUNT_PORT_W = 8;
  localparam int CFG_W        = 8;
  localparam int RSI_W        = 15;

  // 100.0 with 8 fractional bits.
  localparam int RSI_SCALE    = 25600;

  // Window length after reset, and the smallest length a write may set.
  localparam int RESET_WINDOW = 14;
  localparam int MIN_WINDOW   = 2;

  // Operand selection for the shared divider.
  localparam logic DIV_RSI  = 1'b0;
  localparam logic DIV_MEAN = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input price
    logic ring_read;  // read the slot after the oldest price
    logic drop;       // remove the oldest price and difference when full
    logic add;        // insert the new price and difference
    logic prep;       // form the RSI numerator and denominator
    logic div_start;  // start the shared divider
    logic div_sel;    // DIV_RSI or DIV_MEAN
    logic take_rsi;   // store the RSI quotient
    logic take_mean;  // store the mean quotient
    logic load_out;   // move the finished result to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gain_zero;  // gain sum is zero, the RSI is zero
    logic div_done;   // divider quotient is ready
  } dp_status_t;

endpackage

### hw/rtl/wrm_divider.sv
// Restoring shift-and-subtract divider, one quotient bit per cycle.
module wrm_divider
  import wrm_pkg::*;
#(
  parameter int DEN_W = 39,
  parameter int QW    = 39
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DEN_W-1:0]           rem_init,
  input  logic [QW-1:0]              num,
  input  logic [$clog2(QW+1)-1:0]    steps,
  input  logic [DEN_W-1:0]           divisor,
  output logic                       done,
  output logic [QW-1:0]              quotient
);

  localparam int SCW = $clog2(QW + 1);

  logic             busy;
  logic [SCW-1:0]   cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QW-1:0]    num_sh;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_diff;
  logic             fits;

  // One trial subtraction of the divisor from the shifted remainder.
  assign rem_sh   = {rem, num_sh[QW-1]};
  assign rem_diff = rem_sh - {1'b0, den};
  assign fits     = (rem_sh >= {1'b0, den});

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == SCW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - SCW'(1);
        if (cnt == SCW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder, numerator shifter and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      num_sh   <= num;
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_sh   <= num_sh << 1;
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

### hw/rtl/wrm_datapath.sv
// Datapath: price ring, running sums, shared divider and result registers.
module wrm_datapath
  import wrm_pkg::*;
#(
  parameter int MAX_WINDOW = 128,
  parameter int PRICE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic [PRICE_PORT_W-1:0] close_price,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic [RSI_W-1:0]        strength_index,
  output logic [PRICE_PORT_W-1:0] window_mean,
  output logic                    window_full,
  output logic [COUNT_PORT_W-1:0] held_count
);

  localparam int PW        = (PRICE_BITS < PRICE_PORT_W) ? PRICE_BITS : PRICE_PORT_W;
  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int CW        = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = PW + AW;
  localparam int NUM_W     = SUM_W + RSI_W;
  localparam int QW        = (SUM_W > RSI_W) ? SUM_W : RSI_W;
  localparam int SCW       = $clog2(QW + 1);
  localparam int RESET_LEN = (RESET_WINDOW < MAX_WINDOW) ? RESET_WINDOW : MAX_WINDOW;

  // Window state.
  logic [PW-1:0]    ring [MAX_WINDOW];
  logic [PW-1:0]    rd_data;
  logic [CW-1:0]    win_len;
  logic [AW-1:0]    ring_head;
  logic [CW-1:0]    fill_count;
  logic [SUM_W-1:0] gain_total;
  logic [SUM_W-1:0] loss_total;
  logic [SUM_W-1:0] price_total;
  logic [PW-1:0]    price_q;
  logic [PW-1:0]    last_price;
  logic [PW-1:0]    oldest_price;

  logic [AW-1:0]    ring_head_next;
  logic [CW-1:0]    fill_count_next;
  logic [SUM_W-1:0] gain_total_next;
  logic [SUM_W-1:0] loss_total_next;
  logic [SUM_W-1:0] price_total_next;
  logic [CW-1:0]    win_len_next;

  logic             full;
  logic [CW-1:0]    head_inc;
  logic [AW-1:0]    head_adv;
  logic [AW-1:0]    wr_idx;

  // Result computation.
  logic [NUM_W-1:0] rsi_num;
  logic [SUM_W-1:0] rsi_den;
  logic [RSI_W-1:0] rsi_q;
  logic [PW-1:0]    mean_q;

  logic [SUM_W-1:0] div_rem_init;
  logic [QW-1:0]    div_num;
  logic [SCW-1:0]   div_steps;
  logic [SUM_W-1:0] div_divisor;
  logic             div_done;
  logic [QW-1:0]    div_quo;

  // Ring addressing: the oldest price sits at the head once the window is full.
  assign full     = (fill_count == win_len);
  assign head_inc = CW'(ring_head) + CW'(1);
  assign head_adv = (head_inc == win_len) ? '0 : head_inc[AW-1:0];
  assign wr_idx   = full ? ring_head : fill_count[AW-1:0];

  // Clamp a written window length into the supported range.
  always_comb begin
    if (cfg_wr_data < CFG_W'(MIN_WINDOW)) begin
      win_len_next = CW'(MIN_WINDOW);
    end else if ({24'd0, cfg_wr_data} > MAX_WINDOW) begin
      win_len_next = CW'(MAX_WINDOW);
    end else begin
      win_len_next = CW'(cfg_wr_data);
    end
  end

  // Running sums: the oldest difference leaves first, then the newest one enters.
  always_comb begin
    gain_total_next  = gain_total;
    loss_total_next  = loss_total;
    price_total_next = price_total;
    fill_count_next  = fill_count;
    ring_head_next   = ring_head;
    if (cfg_wr_en) begin
      gain_total_next  = '0;
      loss_total_next  = '0;
      price_total_next = '0;
      fill_count_next  = '0;
      ring_head_next   = '0;
    end else if (cmd.drop && full) begin
      if (rd_data >= oldest_price) begin
        gain_total_next = gain_total - SUM_W'(rd_data - oldest_price);
      end else begin
        loss_total_next = loss_total - SUM_W'(oldest_price - rd_data);
      end
      price_total_next = price_total - SUM_W'(oldest_price);
    end else if (cmd.add) begin
      if (fill_count != '0) begin
        if (price_q >= last_price) begin
          gain_total_next = gain_total + SUM_W'(price_q - last_price);
        end else begin
          loss_total_next = loss_total + SUM_W'(last_price - price_q);
        end
      end
      price_total_next = price_total + SUM_W'(price_q);
      if (full) begin
        ring_head_next = head_adv;
      end else begin
        fill_count_next = fill_count + CW'(1);
      end
    end
  end

  // Window control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len     <= CW'(RESET_LEN);
      ring_head   <= '0;
      fill_count  <= '0;
      gain_total  <= '0;
      loss_total  <= '0;
      price_total <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_len <= win_len_next;
      end
      ring_head   <= ring_head_next;
      fill_count  <= fill_count_next;
      gain_total  <= gain_total_next;
      loss_total  <= loss_total_next;
      price_total <= price_total_next;
    end
  end

  // Price ring with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      ring[wr_idx] <= price_q;
    end
    if (cmd.ring_read) begin
      rd_data <= ring[head_adv];
    end
  end

  // Newest and oldest prices are tracked beside the ring.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      price_q <= close_price[PW-1:0];
    end
    if (cmd.add) begin
      last_price <= price_q;
      if (full) begin
        oldest_price <= rd_data;
      end else if (fill_count == '0) begin
        oldest_price <= price_q;
      end
    end
  end

  // RSI operands: 25600 * gain is formed as gain * (2^14 + 2^13 + 2^10).
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rsi_num <= (NUM_W'(gain_total) << 14) + (NUM_W'(gain_total) << 13) +
                 (NUM_W'(gain_total) << 10);
      rsi_den <= gain_total + loss_total;
      rsi_q   <= '0;
    end else if (cmd.take_rsi) begin
      rsi_q <= div_quo[RSI_W-1:0];
    end
    if (cmd.take_mean) begin
      mean_q <= PW'(div_quo);
    end
  end

  // Divider operands. The RSI quotient fits in RSI_W bits, so the upper part of
  // the numerator is already below the divisor and seeds the remainder.
  always_comb begin
    if (cmd.div_sel == DIV_RSI) begin
      div_rem_init = rsi_num[NUM_W-1:RSI_W];
      div_num      = QW'(rsi_num[RSI_W-1:0]) << (QW - RSI_W);
      div_steps    = SCW'(RSI_W);
      div_divisor  = rsi_den;
    end else begin
      div_rem_init = '0;
      div_num      = QW'(price_total) << (QW - SUM_W);
      div_steps    = SCW'(SUM_W);
      div_divisor  = SUM_W'(fill_count);
    end
  end

  wrm_divider #(
    .DEN_W (SUM_W),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (div_rem_init),
    .num      (div_num),
    .steps    (div_steps),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.gain_zero = (gain_total == '0);
  assign status.div_done  = div_done;

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      strength_index <= rsi_q;
      window_mean    <= PRICE_PORT_W'(mean_q);
      window_full    <= full;
      held_count     <= COUNT_PORT_W'(fill_count);
    end
  end

endmodule

### hw/rtl/wrm_ctrl.sv
// Controller: sequences one price through update, one or two divisions and output.
module wrm_ctrl
  import wrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_READ     = 4'd1;
  localparam logic [3:0] ST_DROP     = 4'd2;
  localparam logic [3:0] ST_ADD      = 4'd3;
  localparam logic [3:0] ST_PREP     = 4'd4;
  localparam logic [3:0] ST_RSI_GO   = 4'd5;
  localparam logic [3:0] ST_RSI_RUN  = 4'd6;
  localparam logic [3:0] ST_MEAN_GO  = 4'd7;
  localparam logic [3:0] ST_MEAN_RUN = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        cmd.ring_read = 1'b1;
        state_next    = ST_DROP;
      end
      ST_DROP: begin
        cmd.drop   = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.gain_zero ? ST_MEAN_GO : ST_RSI_GO;
      end
      ST_RSI_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RSI;
        state_next    = ST_RSI_RUN;
      end
      ST_RSI_RUN: begin
        cmd.div_sel = DIV_RSI;
        if (status.div_done) begin
          cmd.take_rsi = 1'b1;
          state_next   = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MEAN;
        state_next    = ST_MEAN_RUN;
      end
      ST_MEAN_RUN: begin
        cmd.div_sel = DIV_MEAN;
        if (status.div_done) begin
          cmd.take_mean = 1'b1;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/windowed_rsi_and_mean.sv
// Windowed relative strength index and mean of closing prices, top level.
//
// Each closing price accepted on the input channel enters a sliding window of
// the last window_length prices and gives one result: the RSI
// 100*gain/(gain+loss) with 8 fractional bits (0 when there is no gain), the
// truncated mean of the window, a full flag and the count of prices held.
// Items are processed one at a time. The single shared restoring divider
// works one quotient bit per cycle, first on the RSI, whose quotient has
// RSI_W = 15 bits, then on the mean, whose quotient has SUM_W bits, where
// SUM_W = min(PRICE_BITS, 32) + clog2(MAX_WINDOW). Each division is started
// from its own state, and the quotient is taken when the divider signals done.
// An item whose gain sum is zero skips the RSI division. A finished result
// waits in an output register, so the next price is taken while it is held.
// Writing window_length (2 to MAX_WINDOW, clamped) empties the window and must
// happen only while the block is idle.
module windowed_rsi_and_mean
  import wrm_pkg::*;
#(
  parameter int MAX_WINDOW = 128,
  parameter int PRICE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PRICE_PORT_W-1:0] close_price,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [RSI_W-1:0]        strength_index,
  output logic [PRICE_PORT_W-1:0] window_mean,
  output logic                    window_full,
  output logic [COUNT_PORT_W-1:0] held_count
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  wrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Window storage, sums and division.
  wrm_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .close_price    (close_price),
    .cmd            (cmd),
    .status         (status),
    .strength_index (strength_index),
    .window_mean    (window_mean),
    .window_full    (window_full),
    .held_count     (held_count)
  );

endmodule

### hw/rtl/wrm_checker.sv
// Port-level checker for the windowed RSI and mean block, with its bind.
module wrm_checker
  import wrm_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [RSI_W-1:0]        strength_index,
  input logic [PRICE_PORT_W-1:0] window_mean,
  input logic                    window_full,
  input logic [COUNT_PORT_W-1:0] held_count
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(strength_index) &&
    $stable(window_mean) && $stable(window_full) && $stable(held_count))
    else $error("result changed while stalled");

  // One item at a time: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // The index never exceeds 100.0.
  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> strength_index <= RSI_W'(RSI_SCALE))
    else $error("strength index above full scale");

  // Every result describes a window holding at least the newest price.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_count != '0)
    else $error("result with an empty window");

  // A full window holds at least the minimum length.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_full |-> held_count >= COUNT_PORT_W'(MIN_WINDOW))
    else $error("window full below minimum length");

endmodule

bind windowed_rsi_and_mean wrm_checker u_wrm_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the windowed RSI and mean block.

// One expected result of the block, at the widths of its output ports.
typedef struct packed {
  logic [wrm_pkg::RSI_W-1:0]        rsi;
  logic [wrm_pkg::PRICE_PORT_W-1:0] mean;
  logic                             full;
  logic [wrm_pkg::COUNT_PORT_W-1:0] count;
} window_result_t;

// Tracks the price window, predicts each result and checks the block's output.
class rsi_mean_tracker;
  localparam int WINDOW_CAP = 128;

  logic [31:0]    ring [WINDOW_CAP];
  int unsigned    head;
  int unsigned    fill;
  int unsigned    win_len;
  bit [63:0]      gain_sum;
  bit [63:0]      loss_sum;
  bit [63:0]      price_sum;
  window_result_t pending_results[$];
  int             error_count;
  int             result_index;

  function new();
    win_len = wrm_pkg::RESET_WINDOW;
    error_count = 0;
    result_index = 0;
    empty_window();
  endfunction

  function void empty_window();
    head = 0;
    fill = 0;
    gain_sum = 0;
    loss_sum = 0;
    price_sum = 0;
  endfunction

  // A length write is clamped to the legal range and empties the window.
  function void set_window(logic [7:0] value);
    int unsigned n;
    n = value;
    if (n < wrm_pkg::MIN_WINDOW) n = wrm_pkg::MIN_WINDOW;
    if (n > WINDOW_CAP) n = WINDOW_CAP;
    win_len = n;
    empty_window();
  endfunction

  // Adds or removes the move from one price to the next in the gain or loss sum.
  function void apply_move(bit [63:0] older, bit [63:0] newer, bit remove);
    if (newer >= older) begin
      gain_sum = remove ? gain_sum - (newer - older) : gain_sum + (newer - older);
    end else begin
      loss_sum = remove ? loss_sum - (older - newer) : loss_sum + (older - newer);
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // Called on every input transfer: updates the window and queues the result.
  function void note_price(logic [31:0] price);
    bit [63:0]      p;
    bit [63:0]      oldest;
    bit [63:0]      second;
    bit [63:0]      newest;
    bit [63:0]      ratio;
    window_result_t want;
    p = price;
    if (fill < win_len) begin
      if (fill > 0) apply_move(ring[(head + fill - 1) % win_len], p, 1'b0);
      ring[(head + fill) % win_len] = price;
      price_sum += p;
      fill++;
    end else begin
      oldest = ring[head];
      second = ring[(head + 1) % win_len];
      newest = ring[(head + win_len - 1) % win_len];
      apply_move(oldest, second, 1'b1);
      apply_move(newest, p, 1'b0);
      price_sum = price_sum - oldest + p;
      ring[head] = price;
      head = (head + 1) % win_len;
    end
    // No gain gives zero, otherwise the scaled ratio truncated toward zero.
    ratio = 0;
    if (gain_sum != 0) ratio = (gain_sum * 64'(wrm_pkg::RSI_SCALE)) / (gain_sum + loss_sum);
    want.rsi   = ratio[wrm_pkg::RSI_W-1:0];
    want.mean  = 32'(price_sum / 64'(fill));
    want.full  = (fill == win_len);
    want.count = 8'(fill);
    pending_results.insert(pending_results.size(), want);
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // Called on every output transfer: compares with the oldest prediction.
  task check_result(logic [wrm_pkg::RSI_W-1:0] rsi, logic [31:0] mean, logic full,
                    logic [7:0] count);
    window_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with no price outstanding: rsi %0d mean %0d",
                                rsi, mean));
      return;
    end
    want = pending_results.pop_front();
    if (rsi !== want.rsi)
      report_mismatch($sformatf("result %0d strength_index %0d, expected %0d",
                                result_index, rsi, want.rsi));
    if (mean !== want.mean)
      report_mismatch($sformatf("result %0d window_mean %0d, expected %0d",
                                result_index, mean, want.mean));
    if (full !== want.full)
      report_mismatch($sformatf("result %0d window_full %0b, expected %0b",
                                result_index, full, want.full));
    if (count !== want.count)
      report_mismatch($sformatf("result %0d held_count %0d, expected %0d",
                                result_index, count, want.count));
    result_index++;
  endtask
endclass

module tb_top;
  import wrm_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1200000;
  localparam int SETTLE_CYCLES = 100;
  localparam int END_WAIT      = 20000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int HOLD_CYCLES   = 1500;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]        cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PRICE_PORT_W-1:0] close_price = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [RSI_W-1:0]        strength_index;
  logic [PRICE_PORT_W-1:0] window_mean;
  logic                    window_full;
  logic [COUNT_PORT_W-1:0] held_count;

  rsi_mean_tracker tracker;

  // Traffic shaping shared between the sender and the receiver.
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int          hold_request = 0;
  int          up_chance = 50;
  longint      walk = 0;
  logic [31:0] last_price = '0;

  windowed_rsi_and_mean i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .close_price    (close_price),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .strength_index (strength_index),
    .window_mean    (window_mean),
    .window_full    (window_full),
    .held_count     (held_count)
  );

  always #CLK_HALF clk = ~clk;

  // Gap lengths: mostly none or short, now and then longer than one item.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (!stalls_on || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // Mostly a trending random walk, with raw words, extremes and repeats mixed in.
  function automatic logic [31:0] next_price();
    int     pick;
    longint step;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      step = $urandom_range(0, 3000);
      if ($urandom_range(0, 99) < up_chance) walk = walk + step;
      else walk = walk - step;
      if (walk < 0) walk = 0;
      if (walk > 64'hFFFF_FFFF) walk = 64'hFFFF_FFFF;
      last_price = walk[31:0];
    end else if (pick < 86) begin
      last_price = $urandom();
    end else if (pick < 91) begin
      last_price = '0;
    end else if (pick < 96) begin
      last_price = '1;
    end
    return last_price;
  endfunction

  // Offers one price after a gap and waits for its transfer.
  task automatic send_price(input logic [31:0] price, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    close_price <= price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_price(price);
  endtask

  // Stops offering until every result has come back, then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [7:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_window(value);
  endtask

  // Receiver: checks each output transfer and paces out_ready.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_result(strength_index, window_mean, window_full, held_count);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_stall();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Guards against a hung handshake.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] fixed_len [7];
    logic [7:0] len;
    int         produced;
    int         phase;
    int         phase_items;
    int         k;
    tracker = new();
    fixed_len = '{8'd128, 8'd1, 8'd255, 8'd3, 8'd129, 8'd0, 8'd2};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset length: a single price, a flat step, a pure gain, another flat step, then a loss.
    send_price(32'h0000_0000, 0);
    send_price(32'h0000_0000, 0);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'h0000_0000, 0);
    // A zigzag that fills the window and then replaces its two oldest prices.
    for (k = 0; k < 11; k++) send_price((k % 2) ? 32'd900 : 32'(1000 + 100 * k), 0);

    // Shortest window: only a loss, then a gain that replaces it, then no move.
    write_window(8'd2);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'h0000_0000, 0);
    send_price(32'hFFFF_FFFF, 0);
    send_price(32'hFFFF_FFFF, 0);
    // Lengths out of range are clamped.
    write_window(8'd0);
    send_price(32'h0000_0001, 0);
    send_price(32'h0000_0003, 0);
    write_window(8'd255);
    send_price(32'h8000_0000, 0);
    send_price(32'h7FFF_FFFF, 0);

    // Random phases, each with its own window length and traffic shape.
    produced = 0;
    phase = 0;
    while (produced < RANDOM_ITEMS) begin
      if (phase < 7) len = fixed_len[phase];
      else if ($urandom_range(0, 1)) len = 8'($urandom_range(2, 40));
      else len = 8'($urandom_range(0, 255));
      write_window(len);
      gaps_on   = (phase % 5 != 1);
      stalls_on = (phase % 5 != 1) && (phase % 3 != 2);
      case ($urandom_range(0, 4))
        0: up_chance = 100;
        1: up_chance = 0;
        default: up_chance = $urandom_range(20, 80);
      endcase
      walk = $urandom();
      phase_items = 2 * tracker.win_len + $urandom_range(5, 40);
      for (k = 0; k < phase_items; k++) begin
        // Long receiver hold-off so the block backs up into its input.
        if (phase == 0 && k == 20) hold_request = HOLD_CYCLES;
        // Sender pause until the block has drained.
        if (phase == 2 && k == phase_items / 2) wait_idle();
        send_price(next_price(), pick_gap());
      end
      produced += phase_items;
      phase++;
    end

    // Drain with a bound, then settle.
    in_valid <= 1'b0;
    k = 0;
    while (tracker.pending() != 0 && k < END_WAIT) begin
      @(posedge clk);
      k++;
    end
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
